// ----- hdl/aftp_pkg.sv -----
// Shared types and constants of the aspect-fit threshold packer.
// Command and status structs between controller and datapath, register codes.
`timescale 1ns / 1ps

package aftp_pkg;

    localparam int OP_W      = 1;
    localparam int PADDR_W   = 17;
    localparam int PVAL_W    = 8;
    localparam int COL_W     = 9;
    localparam int BROW_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_FIX = 2'd3;

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_16   = 2'd1;

    localparam logic [8:0] MAX_MONO = 9'd1;
    localparam logic [8:0] MAX_16   = 9'd15;
    localparam logic [8:0] MAX_256  = 9'd255;

    localparam logic [8:0] RST_SRC_WIDTH  = 9'd160;
    localparam logic [7:0] RST_SRC_HEIGHT = 8'd80;

    localparam logic [15:0] FIX_SW    = 16'd160;
    localparam logic [15:0] FIX_SH    = 16'd80;
    localparam logic [15:0] FIX_X_LO  = 16'd36;
    localparam logic [15:0] FIX_X_HI  = 16'd44;
    localparam logic [15:0] FIX_Y_LO  = 16'd58;
    localparam logic [15:0] FIX_Y_HI  = 16'd67;

    typedef enum logic [1:0] {
        DIV_TH = 2'd0,
        DIV_TW = 2'd1,
        DIV_SX = 2'd2,
        DIV_SY = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     take;
        logic     div_go;
        t_div_sel div_sel;
        logic     geo;
        logic     col_chk;
        logic     row_chk;
        logic     bit_next;
        logic     idx_calc;
        logic     mem_rd;
        logic     eval;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic req_read;
        logic div_done;
        logic th_big;
        logic col_ok;
        logic row_ok;
        logic last_bit;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/aftp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by aftp_datapath.
`timescale 1ns / 1ps

module aftp_div #(
    parameter int N_W = 22,
    parameter int D_W = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     rem_sh;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[N_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_cnt = CNT_W'(N_W);
            n_quo = i_num;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            n_quo  = {r_quo[N_W-2:0], ge};
            n_rem  = ge ? D_W'(rem_sh - {1'b0, r_den}) : rem_sh[D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- hdl/aftp_datapath.sv -----
// Datapath: configuration registers, source pixel memory, fit geometry,
// sampling divider and byte assembly. Depends on aftp_pkg and aftp_div.
`timescale 1ns / 1ps

module aftp_datapath #(
    parameter int PANEL_WIDTH       = 296,
    parameter int PANEL_HEIGHT      = 152,
    parameter int MAX_SOURCE_WIDTH  = 320,
    parameter int MAX_SOURCE_HEIGHT = 240
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aftp_pkg::t_cmd                    i_cmd,
    output aftp_pkg::t_status                 o_status,
    input  logic                              i_in_valid,
    input  logic [aftp_pkg::OP_W-1:0]         i_operation,
    input  logic [aftp_pkg::PADDR_W-1:0]      i_pixel_address,
    input  logic [aftp_pkg::PVAL_W-1:0]       i_pixel_value,
    input  logic [aftp_pkg::COL_W-1:0]        i_panel_column,
    input  logic [aftp_pkg::BROW_W-1:0]       i_panel_byte_row,
    input  logic                              i_cfg_valid,
    input  logic [aftp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aftp_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [aftp_pkg::BYTE_W-1:0]       o_panel_byte
);

    import aftp_pkg::*;

    localparam int SW_W   = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int SH_W   = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int PW_W   = $clog2(PANEL_WIDTH + 1);
    localparam int PH_W   = $clog2(PANEL_HEIGHT + 1);
    localparam int P1     = SH_W + PW_W;
    localparam int P2     = SW_W + PH_W;
    localparam int P12    = (P1 > P2) ? P1 : P2;
    localparam int DIV_N  = (P12 > PW_W + SW_W) ? P12 : PW_W + SW_W;
    localparam int D12    = (SW_W > SH_W) ? SW_W : SH_W;
    localparam int D34    = (PW_W > PH_W) ? PW_W : PH_W;
    localparam int DIV_D  = (D12 > D34) ? D12 : D34;
    localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WA_W   = ((ADDR_W + 1) > PADDR_W) ? (ADDR_W + 1) : PADDR_W;
    localparam int XW     = ((PW_W > COL_W) ? PW_W : COL_W) + 1;
    localparam int YW     = ((PH_W > BROW_W + 3) ? PH_W : BROW_W + 3) + 1;
    localparam int BROWS  = (PANEL_HEIGHT + 7) / 8;
    localparam int CWW    = (SW_W > CFG_DAT_W) ? SW_W : CFG_DAT_W;
    localparam int CHW    = (SH_W > 8) ? SH_W : 8;

    logic [8:0]        r_src_w;
    logic [7:0]        r_src_h;
    logic [1:0]        r_mode;
    logic              r_fix;
    logic [SW_W-1:0]   sw;
    logic [SH_W-1:0]   sh;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd;
    logic              wr_en;

    logic [COL_W-1:0]  r_col;
    logic [BROW_W-1:0] r_brow;
    logic [2:0]        r_bit;
    logic [BYTE_W-1:0] r_acc;

    logic [PH_W-1:0]   r_th;
    logic [PW_W-1:0]   r_tw;
    logic              r_th_big;
    logic [PW_W-1:0]   r_xo;
    logic [PH_W-1:0]   r_yo;
    logic              r_empty;
    logic [PW_W-1:0]   r_x;
    logic [PH_W-1:0]   r_y;
    logic              r_col_ok;
    logic              r_row_ok;
    logic [SW_W-1:0]   r_sx;
    logic [SH_W-1:0]   r_sy;
    logic [ADDR_W-1:0] r_idx;

    t_div_sel          r_sel;
    logic [DIV_N-1:0]  div_num;
    logic [DIV_D-1:0]  div_den;
    logic              div_done;
    logic [DIV_N-1:0]  div_quo;

    logic [XW-1:0]     col_e, xo_e, xend_e;
    logic [YW-1:0]     py_e, yo_e, yend_e;
    logic [8:0]        maxv;
    logic              black;
    logic              fix_hit;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              out_free;
    logic              take;

    // clamp source dimensions
    always_comb begin
        if (r_src_w == '0) begin
            sw = SW_W'(1);
        end else if (CWW'(r_src_w) > CWW'(MAX_SOURCE_WIDTH)) begin
            sw = SW_W'(MAX_SOURCE_WIDTH);
        end else begin
            sw = SW_W'(r_src_w);
        end
        if (r_src_h == '0) begin
            sh = SH_W'(1);
        end else if (CHW'(r_src_h) > CHW'(MAX_SOURCE_HEIGHT)) begin
            sh = SH_W'(MAX_SOURCE_HEIGHT);
        end else begin
            sh = SH_W'(r_src_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_mode  <= MODE_MONO;
            r_fix   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[7:0];
                CFG_COLOR_MODE: r_mode  <= i_cfg_data[1:0];
                CFG_STATUS_FIX: r_fix   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign take  = i_cmd.take && i_in_valid;
    assign wr_en = take && (i_operation == OP_WRITE)
                   && (WA_W'(i_pixel_address) < WA_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ADDR_W'(i_pixel_address)] <= i_pixel_value;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_TW: begin
                div_num = DIV_N'(sw) * DIV_N'(PANEL_HEIGHT);
                div_den = DIV_D'(sh);
            end
            DIV_SX: begin
                div_num = DIV_N'(r_x) * DIV_N'(sw);
                div_den = DIV_D'(r_tw);
            end
            DIV_SY: begin
                div_num = DIV_N'(r_y) * DIV_N'(sh);
                div_den = DIV_D'(r_th);
            end
            default: begin
                div_num = DIV_N'(sh) * DIV_N'(PANEL_WIDTH);
                div_den = DIV_D'(sw);
            end
        endcase
    end

    aftp_div #(
        .N_W (DIV_N),
        .D_W (DIV_D)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        col_e  = XW'(r_col);
        xo_e   = XW'(r_xo);
        xend_e = XW'(r_xo) + XW'(r_tw);
        py_e   = YW'({r_brow, r_bit});
        yo_e   = YW'(r_yo);
        yend_e = YW'(r_yo) + YW'(r_th);
        case (r_mode)
            MODE_MONO: maxv = MAX_MONO;
            MODE_16:   maxv = MAX_16;
            default:   maxv = MAX_256;
        endcase
        fix_hit = r_fix && (r_mode == MODE_16) && (r_rd == '0)
                  && (16'(sw) == FIX_SW) && (16'(sh) == FIX_SH)
                  && (16'(r_sx) inside {[FIX_X_LO:FIX_X_HI]})
                  && (16'(r_sy) inside {[FIX_Y_LO:FIX_Y_HI]});
        black   = ({r_rd, 1'b0} > maxv) || fix_hit;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_col  <= i_panel_column;
            r_brow <= i_panel_byte_row;
            r_acc  <= '0;
        end
        if (i_cmd.div_go) begin
            r_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            case (r_sel)
                DIV_TH: begin
                    r_th_big <= div_quo > DIV_N'(PANEL_HEIGHT);
                    r_th     <= (div_quo > DIV_N'(PANEL_HEIGHT)) ?
                                PH_W'(PANEL_HEIGHT) : div_quo[PH_W-1:0];
                    r_tw     <= PW_W'(PANEL_WIDTH);
                end
                DIV_TW:  r_tw <= div_quo[PW_W-1:0];
                DIV_SX:  r_sx <= div_quo[SW_W-1:0];
                default: r_sy <= div_quo[SH_W-1:0];
            endcase
        end
        if (i_cmd.geo) begin
            r_xo    <= (PW_W'(PANEL_WIDTH) - r_tw) >> 1;
            r_yo    <= (PH_W'(PANEL_HEIGHT) - r_th) >> 1;
            r_empty <= (r_tw == '0) || (r_th == '0);
        end
        if (i_cmd.col_chk) begin
            r_col_ok <= !r_empty && (col_e < XW'(PANEL_WIDTH))
                        && (YW'(r_brow) < YW'(BROWS))
                        && (col_e >= xo_e) && (col_e < xend_e);
            r_x      <= PW_W'(col_e - xo_e);
            r_bit    <= '0;
        end
        if (i_cmd.row_chk) begin
            r_row_ok <= (py_e < YW'(PANEL_HEIGHT)) && (py_e >= yo_e) && (py_e < yend_e);
            r_y      <= PH_W'(py_e - yo_e);
        end
        if (i_cmd.idx_calc) begin
            r_idx <= ADDR_W'(ADDR_W'(r_sy) * ADDR_W'(sw)) + ADDR_W'(r_sx);
        end
        if (i_cmd.eval && black) begin
            r_acc[3'd7 - r_bit] <= 1'b1;
        end
        if (i_cmd.bit_next) begin
            r_bit <= r_bit + 3'd1;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_acc;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.req_read = i_in_valid && (i_operation == OP_READ);
    assign o_status.div_done = div_done;
    assign o_status.th_big   = r_th_big;
    assign o_status.col_ok   = r_col_ok;
    assign o_status.row_ok   = r_row_ok;
    assign o_status.last_bit = (r_bit == 3'd7);
    assign o_status.out_free = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_panel_byte = r_out_byte;

endmodule

// ----- hdl/aftp_ctrl.sv -----
// Controller state machine: sequences fit, column, and per-bit sampling.
// Depends on aftp_pkg; drives aftp_datapath through t_cmd.
`timescale 1ns / 1ps

module aftp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aftp_pkg::t_status i_status,
    output aftp_pkg::t_cmd    o_cmd
);

    import aftp_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_TH_GO   = 16'h0002,
        S_TH_WAIT = 16'h0004,
        S_TW_GO   = 16'h0008,
        S_TW_WAIT = 16'h0010,
        S_GEO     = 16'h0020,
        S_COL     = 16'h0040,
        S_SX_GO   = 16'h0080,
        S_SX_WAIT = 16'h0100,
        S_ROW     = 16'h0200,
        S_SY_GO   = 16'h0400,
        S_SY_WAIT = 16'h0800,
        S_ADDR    = 16'h1000,
        S_READ    = 16'h2000,
        S_EVAL    = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_status.req_read) begin
                    n_state = S_TH_GO;
                end
            end
            S_TH_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_TH;
                n_state       = S_TH_WAIT;
            end
            S_TH_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_TW_GO;
                end
            end
            S_TW_GO: begin
                if (i_status.th_big) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_TW;
                    n_state       = S_TW_WAIT;
                end else begin
                    n_state = S_GEO;
                end
            end
            S_TW_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_GEO;
                end
            end
            S_GEO: begin
                o_cmd.geo = 1'b1;
                n_state   = S_COL;
            end
            S_COL: begin
                o_cmd.col_chk = 1'b1;
                n_state       = S_SX_GO;
            end
            S_SX_GO: begin
                if (i_status.col_ok) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_SX;
                    n_state       = S_SX_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SX_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_chk = 1'b1;
                n_state       = S_SY_GO;
            end
            S_SY_GO: begin
                if (i_status.row_ok) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_SY;
                    n_state       = S_SY_WAIT;
                end else begin
                    o_cmd.bit_next = 1'b1;
                    n_state        = i_status.last_bit ? S_DONE : S_ROW;
                end
            end
            S_SY_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.idx_calc = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval     = 1'b1;
                o_cmd.bit_next = 1'b1;
                n_state        = i_status.last_bit ? S_DONE : S_ROW;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/aspect_fit_threshold_packer.sv -----
// Top level of the aspect-fit threshold packer: controller plus datapath.
// Depends on aftp_pkg, aftp_ctrl, aftp_datapath, aftp_div.
//
// A pixel write is taken while the controller is idle. A panel byte read runs
// through one shared bit-serial divider of N = max(product widths) bits (18
// at default sizes): one or two divisions for the fit, one for the column and
// one per covered panel row. Each covered row also passes through row check,
// address, memory read and threshold; a row outside the fit stops after its
// row check. The result sits in an output register, so the next item is
// taken while it waits. Unwritten source pixels read undefined.
`timescale 1ns / 1ps

module aspect_fit_threshold_packer #(
    parameter int PANEL_WIDTH       = 296,
    parameter int PANEL_HEIGHT      = 152,
    parameter int MAX_SOURCE_WIDTH  = 320,
    parameter int MAX_SOURCE_HEIGHT = 240
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [aftp_pkg::OP_W-1:0]         i_operation,
    input  logic [aftp_pkg::PADDR_W-1:0]      i_pixel_address,
    input  logic [aftp_pkg::PVAL_W-1:0]       i_pixel_value,
    input  logic [aftp_pkg::COL_W-1:0]        i_panel_column,
    input  logic [aftp_pkg::BROW_W-1:0]       i_panel_byte_row,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [aftp_pkg::BYTE_W-1:0]       o_panel_byte,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aftp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aftp_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    import aftp_pkg::*;

    t_cmd    cmd;
    t_status status;

    aftp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    aftp_datapath #(
        .PANEL_WIDTH       (PANEL_WIDTH),
        .PANEL_HEIGHT      (PANEL_HEIGHT),
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_valid       (i_in_valid),
        .i_operation      (i_operation),
        .i_pixel_address  (i_pixel_address),
        .i_pixel_value    (i_pixel_value),
        .i_panel_column   (i_panel_column),
        .i_panel_byte_row (i_panel_byte_row),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_panel_byte     (o_panel_byte)
    );

    assign o_in_stall  = !cmd.take;
    assign o_cfg_ready = 1'b1;

endmodule
